FILE: rtl/cpbb_pkg.sv
// Shared types and constants for the changed-pixel bounding box block.
package cpbb_pkg;

  localparam int PIX_W       = 32;
  localparam int COORD_W     = 12;
  localparam int SIZE_W      = 13;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 13;
  localparam int COUNT_LIMIT = 4096;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [SIZE_W-1:0]  size_t;

  localparam size_t WIDTH_RESET  = 13'd1920;
  localparam size_t HEIGHT_RESET = 13'd1080;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    coord_t min_col;
    coord_t min_row;
    coord_t max_col;
    coord_t max_row;
    logic   found;
  } box_t;

  // A size of zero acts as one; anything above the limit saturates there.
  function automatic size_t clamp_size(size_t reg_val, size_t lim);
    size_t r;
    if (reg_val == '0) begin
      r = size_t'(1);
    end else if (reg_val > lim) begin
      r = lim;
    end else begin
      r = reg_val;
    end
    return r;
  endfunction

endpackage

FILE: rtl/cpbb_pix_if.sv
// Pixel-pair input channel: reference and captured pixel with valid/ready.
interface cpbb_pix_if;
  logic                      valid;
  logic                      ready;
  logic [cpbb_pkg::PIX_W-1:0] reference_pixel;
  logic [cpbb_pkg::PIX_W-1:0] captured_pixel;

  modport source (output valid, output reference_pixel, output captured_pixel, input ready);
  modport sink   (input valid, input reference_pixel, input captured_pixel, output ready);
endinterface

FILE: rtl/cpbb_box_if.sv
// Result channel: one bounding box per frame with valid/ready.
interface cpbb_box_if;
  logic                 valid;
  logic                 ready;
  cpbb_pkg::coord_t     box_min_col;
  cpbb_pkg::coord_t     box_min_row;
  cpbb_pkg::coord_t     box_max_col;
  cpbb_pkg::coord_t     box_max_row;
  logic                 box_found;

  modport source (output valid, output box_min_col, output box_min_row, output box_max_col,
                  output box_max_row, output box_found, input ready);
  modport sink   (input valid, input box_min_col, input box_min_row, input box_max_col,
                  input box_max_row, input box_found, output ready);
endinterface

FILE: rtl/cpbb_tracker.sv
// Raster position counters and running box extremes for the current frame.
module cpbb_tracker (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic             diff,
  input  cpbb_pkg::size_t  width,
  input  cpbb_pkg::size_t  height,
  output logic             last,
  output cpbb_pkg::box_t   result
);
  import cpbb_pkg::*;

  coord_t col;
  coord_t row;
  box_t   box;

  coord_t col_next;
  coord_t row_next;
  box_t   box_upd;
  box_t   box_next;
  size_t  col_inc;
  size_t  row_inc;
  logic   row_end;

  always_comb begin
    col_inc = {1'b0, col} + size_t'(1);
    row_inc = {1'b0, row} + size_t'(1);
    row_end = (col_inc >= width);
    last    = row_end && (row_inc >= height);

    // Fold the current pixel into the box; the first hit seeds all corners.
    box_upd = box;
    if (diff && !box.found) begin
      box_upd.min_col = col;
      box_upd.max_col = col;
      box_upd.min_row = row;
      box_upd.max_row = row;
      box_upd.found   = 1'b1;
    end else if (diff) begin
      if (col < box.min_col) box_upd.min_col = col;
      if (col > box.max_col) box_upd.max_col = col;
      if (row < box.min_row) box_upd.min_row = row;
      if (row > box.max_row) box_upd.max_row = row;
    end

    result = box_upd.found ? box_upd : '0;

    if (!row_end) begin
      col_next = col_inc[COORD_W-1:0];
      row_next = row;
    end else if (!last) begin
      col_next = '0;
      row_next = row_inc[COORD_W-1:0];
    end else begin
      col_next = '0;
      row_next = '0;
    end

    box_next = last ? '0 : box_upd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
      box <= '0;
    end else if (step) begin
      col <= col_next;
      row <= row_next;
      box <= box_next;
    end
  end

endmodule

FILE: rtl/changed_pixel_bounding_box.sv
// Top level of the changed-pixel bounding box block.
//
//   channel  direction  beat contents
//   pix      in         reference_pixel, captured_pixel (one raster position)
//   box      out        box_min_col/row, box_max_col/row, box_found (one per frame)
//   wr_*     in         frame_width (index 0), frame_height (index 1)
//
// Every pixel beat passes through an input register holding the compare result,
// then one step of the position counters and box extremes; the step on a frame's
// last pixel loads the result register and raises box.valid.
// Reset is synchronous: the counters and box clear, the sizes return to
// 1920 x 1080, and no result is pending.
// A beat is taken every clock; a box-channel stall holds the pipeline only when the
// pixel in the input register closes a frame and the result register is still full.
module changed_pixel_bounding_box #(
  parameter int MAX_FRAME_WIDTH  = 4096,
  parameter int MAX_FRAME_HEIGHT = 4096
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 wr_en,
  input  logic [cpbb_pkg::CFG_IDX_W-1:0]       wr_index,
  input  logic [cpbb_pkg::CFG_DATA_W-1:0]      wr_data,
  cpbb_pix_if.sink                             pix,
  cpbb_box_if.source                           box
);
  import cpbb_pkg::*;

  // The 12-bit counters cannot reach past 4096 positions.
  localparam int    W_LIM_INT = (MAX_FRAME_WIDTH < COUNT_LIMIT) ? MAX_FRAME_WIDTH : COUNT_LIMIT;
  localparam int    H_LIM_INT = (MAX_FRAME_HEIGHT < COUNT_LIMIT) ? MAX_FRAME_HEIGHT : COUNT_LIMIT;
  localparam size_t W_LIM     = size_t'(W_LIM_INT);
  localparam size_t H_LIM     = size_t'(H_LIM_INT);

  // Configuration registers.
  size_t frame_width;
  size_t frame_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= WIDTH_RESET;
      frame_height <= HEIGHT_RESET;
    end else if (wr_en) begin
      unique case (cfg_reg_t'(wr_index))
        REG_FRAME_WIDTH:  frame_width  <= wr_data;
        REG_FRAME_HEIGHT: frame_height <= wr_data;
        default: ;
      endcase
    end
  end

  size_t width_eff;
  size_t height_eff;

  assign width_eff  = clamp_size(frame_width, W_LIM);
  assign height_eff = clamp_size(frame_height, H_LIM);

  // Input register: only whether the two pixels differ is kept.
  logic s1_valid;
  logic s1_diff;
  logic s1_go;
  logic out_free;
  logic last;
  box_t result;

  // The result register must have room only when this pixel closes a frame.
  assign out_free  = !box.valid || box.ready;
  assign s1_go     = s1_valid && (!last || out_free);
  assign pix.ready = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pix.ready) begin
      s1_valid <= pix.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pix.valid && pix.ready) begin
      s1_diff <= (pix.reference_pixel != pix.captured_pixel);
    end
  end

  cpbb_tracker u_tracker (
    .clk    (clk),
    .rst    (rst),
    .step   (s1_go),
    .diff   (s1_diff),
    .width  (width_eff),
    .height (height_eff),
    .last   (last),
    .result (result)
  );

  // Result register.
  box_t out_box;

  always_ff @(posedge clk) begin
    if (rst) begin
      box.valid <= 1'b0;
    end else if (s1_go && last) begin
      box.valid <= 1'b1;
    end else if (box.ready) begin
      box.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && last) begin
      out_box <= result;
    end
  end

  assign box.box_min_col = out_box.min_col;
  assign box.box_min_row = out_box.min_row;
  assign box.box_max_col = out_box.max_col;
  assign box.box_max_row = out_box.max_row;
  assign box.box_found   = out_box.found;

  // A held pixel means a finished frame is waiting behind a full result register.
  a_hold_only_on_full: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_go) |-> (box.valid && !box.ready))
    else $error("input register held without a blocked result");

  // An empty frame reports all corners as zero.
  a_empty_is_zero: assert property (@(posedge clk) disable iff (rst)
    (box.valid && !box.box_found) |->
      (box.box_min_col == '0 && box.box_min_row == '0 &&
       box.box_max_col == '0 && box.box_max_row == '0))
    else $error("empty frame result has nonzero corners");

  // A found box is never inverted.
  a_box_ordered: assert property (@(posedge clk) disable iff (rst)
    (box.valid && box.box_found) |->
      (box.box_min_col <= box.box_max_col && box.box_min_row <= box.box_max_row))
    else $error("result box corners out of order");

  // A pending result is not dropped while the sink stalls.
  a_result_kept: assert property (@(posedge clk) disable iff (rst)
    (box.valid && !box.ready) |=> box.valid)
    else $error("pending result lost");

endmodule

FILE: test/changed_pixel_bounding_box_test.sv
// Self-checking testbench for the changed-pixel bounding box block.
`timescale 1ns / 100ps

import cpbb_pkg::*;

// Tracks the raster position and the box of changed pixels the same way the
// block should, and holds the boxes still owed by the block in arrival order.
class bbox_tracker;
  size_t       width_reg;
  size_t       height_reg;
  int unsigned width_cap;
  int unsigned height_cap;
  coord_t      col_pos;
  coord_t      row_pos;
  coord_t      left;
  coord_t      top;
  coord_t      right;
  coord_t      bottom;
  bit          changed;
  box_t        owed_boxes[$];
  int unsigned pairs_seen;
  int unsigned boxes_owed;
  int unsigned boxes_with_change;
  int unsigned boxes_checked;
  int unsigned mismatches;

  function new(int unsigned max_w, int unsigned max_h);
    width_cap  = (max_w < COUNT_LIMIT) ? max_w : COUNT_LIMIT;
    height_cap = (max_h < COUNT_LIMIT) ? max_h : COUNT_LIMIT;
    if (width_cap < 1) width_cap = 1;
    if (height_cap < 1) height_cap = 1;
    width_reg  = WIDTH_RESET;
    height_reg = HEIGHT_RESET;
    col_pos    = '0;
    row_pos    = '0;
    clear_box();
  endfunction

  function void clear_box();
    left    = '0;
    top     = '0;
    right   = '0;
    bottom  = '0;
    changed = 1'b0;
  endfunction

  function void write_size(cfg_reg_t idx, size_t value);
    case (idx)
      REG_FRAME_WIDTH:  width_reg = value;
      REG_FRAME_HEIGHT: height_reg = value;
      default: ;
    endcase
  endfunction

  // Zero behaves as one, and anything past the counter reach saturates.
  function int unsigned span(size_t reg_val, int unsigned cap);
    if (reg_val == '0) return 1;
    if (int'(reg_val) > cap) return cap;
    return {19'd0, reg_val};
  endfunction

  function int unsigned frame_cols();
    return span(width_reg, width_cap);
  endfunction

  function int unsigned frame_rows();
    return span(height_reg, height_cap);
  endfunction

  function void take_pair(logic [PIX_W-1:0] ref_pix, logic [PIX_W-1:0] cap_pix);
    int unsigned col;
    int unsigned row;
    box_t        done;
    col = {20'd0, col_pos};
    row = {20'd0, row_pos};
    pairs_seen++;
    if (ref_pix != cap_pix) begin
      if (!changed) begin
        left    = col_pos;
        right   = col_pos;
        top     = row_pos;
        bottom  = row_pos;
        changed = 1'b1;
      end else begin
        if (col_pos < left) left = col_pos;
        if (col_pos > right) right = col_pos;
        if (row_pos < top) top = row_pos;
        if (row_pos > bottom) bottom = row_pos;
      end
    end
    // A shrink in mid-frame can leave the counters past the new edge; the
    // "less than" tests below then close the row or frame on this pixel.
    if (col + 1 < frame_cols()) begin
      col_pos = coord_t'(col + 1);
      return;
    end
    col_pos = '0;
    if (row + 1 < frame_rows()) begin
      row_pos = coord_t'(row + 1);
      return;
    end
    row_pos = '0;
    if (changed) begin
      done.min_col = left;
      done.min_row = top;
      done.max_col = right;
      done.max_row = bottom;
      done.found   = 1'b1;
      boxes_with_change++;
    end else begin
      done = '0;
    end
    owed_boxes.push_back(done);
    boxes_owed++;
    clear_box();
  endfunction

  function void check_box(box_t got);
    box_t want;
    if (owed_boxes.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("Box with nothing owed: min (%0d,%0d) max (%0d,%0d) found %0b",
                 got.min_col, got.min_row, got.max_col, got.max_row, got.found);
      return;
    end
    want = owed_boxes.pop_front();
    boxes_checked++;
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display({"Box %0d wrong: expected min (%0d,%0d) max (%0d,%0d) found %0b,",
                  " got min (%0d,%0d) max (%0d,%0d) found %0b"},
                 boxes_checked, want.min_col, want.min_row, want.max_col, want.max_row,
                 want.found, got.min_col, got.min_row, got.max_col, got.max_row,
                 got.found);
    end
  endfunction

  function int pending();
    return owed_boxes.size();
  endfunction
endclass

module changed_pixel_bounding_box_test;

  localparam int MAX_W         = 4096;
  localparam int MAX_H         = 4096;
  localparam int SETTLE_CYCLES = 4;
  localparam int CYCLE_LIMIT   = 1_500_000;
  localparam int RANDOM_PAIRS  = 1300;
  localparam int RANDOM_BOXES  = 48;

  logic clk;
  logic rst;
  logic wr_en;
  logic [CFG_IDX_W-1:0]  wr_index;
  logic [CFG_DATA_W-1:0] wr_data;

  cpbb_pix_if pix_ch ();
  cpbb_box_if box_ch ();

  changed_pixel_bounding_box #(
    .MAX_FRAME_WIDTH  (MAX_W),
    .MAX_FRAME_HEIGHT (MAX_H)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .pix      (pix_ch),
    .box      (box_ch)
  );

  bbox_tracker tracker;
  // When set, neither side inserts gaps, so beats run back to back.
  bit          quiet;
  int unsigned cycles;
  int unsigned size_settings;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog: a hung handshake or a lost box ends the run here.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d boxes outstanding.",
               cycles, tracker.pending());
      $display("changed_pixel_bounding_box regression: fail");
      $finish;
    end
  end

  // One pixel-pair beat. The gap before it is drawn per beat, and the
  // tracker learns about the pair only once the block has taken it.
  task automatic send_pair(input logic [PIX_W-1:0] ref_pix,
                           input logic [PIX_W-1:0] cap_pix);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 8);
    repeat (gap) begin
      @(negedge clk);
      pix_ch.valid <= 1'b0;
    end
    @(negedge clk);
    pix_ch.valid           <= 1'b1;
    pix_ch.reference_pixel <= ref_pix;
    pix_ch.captured_pixel  <= cap_pix;
    @(posedge clk);
    while (!pix_ch.ready) @(posedge clk);
    tracker.take_pair(ref_pix, cap_pix);
  endtask

  // A random pair, changed or not. Changes are a single flipped bit, a fresh
  // random word, or every bit inverted.
  task automatic send_random_pair(input bit differ);
    logic [PIX_W-1:0] ref_pix;
    logic [PIX_W-1:0] cap_pix;
    ref_pix = $urandom;
    cap_pix = ref_pix;
    if (differ) begin
      case ($urandom_range(0, 2))
        0: cap_pix = ref_pix ^ (32'd1 << $urandom_range(0, 31));
        1: begin
          cap_pix = $urandom;
          if (cap_pix == ref_pix) cap_pix = ~ref_pix;
        end
        default: cap_pix = ~ref_pix;
      endcase
    end
    send_pair(ref_pix, cap_pix);
  endtask

  // The last beat was taken at a rising edge; drop valid before the next one
  // so that beat is not offered again while waiting.
  task automatic wait_drained();
    @(negedge clk);
    pix_ch.valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  // Sizes only change while the block is idle: every box owed has come, and
  // the pipeline has had time to retire pixels that close no frame.
  task automatic write_size(input cfg_reg_t idx, input size_t value);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    pix_ch.valid <= 1'b0;
    wr_en        <= 1'b1;
    wr_index     <= idx;
    wr_data      <= value;
    @(negedge clk);
    wr_en <= 1'b0;
    tracker.write_size(idx, value);
  endtask

  task automatic set_frame(input size_t w, input size_t h);
    write_size(REG_FRAME_WIDTH, w);
    write_size(REG_FRAME_HEIGHT, h);
    size_settings++;
  endtask

  // One full frame at the current size, changed pixels at the given percent.
  // Forcing the last pixel to differ pushes the box to the far corner.
  task automatic send_frame(input int pct, input bit mark_last);
    int unsigned total;
    total = tracker.frame_cols() * tracker.frame_rows();
    for (int unsigned i = 0; i < total; i++)
      send_random_pair(($urandom_range(0, 99) < pct) || (mark_last && i == total - 1));
  endtask

  // Result side: ready drops for a drawn number of cycles before each beat.
  initial begin : box_drain
    int   stall;
    box_t got;
    wait (rst == 1'b0);
    forever begin
      stall = quiet ? 0 : $urandom_range(0, 8);
      repeat (stall) begin
        @(negedge clk);
        box_ch.ready <= 1'b0;
      end
      @(negedge clk);
      box_ch.ready <= 1'b1;
      @(posedge clk);
      while (!box_ch.valid) @(posedge clk);
      got.min_col = box_ch.box_min_col;
      got.min_row = box_ch.box_min_row;
      got.max_col = box_ch.box_max_col;
      got.max_row = box_ch.box_max_row;
      got.found   = box_ch.box_found;
      tracker.check_box(got);
    end
  end

  initial begin : stimulus
    int          sel;
    int          pct;
    int unsigned pairs;
    int unsigned frame_pix;
    int unsigned random_pairs;
    size_t       w;
    size_t       h;

    tracker                = new(MAX_W, MAX_H);
    quiet                  = 1'b0;
    cycles                 = 0;
    size_settings          = 0;
    random_pairs           = 0;
    rst                    = 1'b1;
    wr_en                  = 1'b0;
    wr_index               = '0;
    wr_data                = '0;
    pix_ch.valid           = 1'b0;
    pix_ch.reference_pixel = '0;
    pix_ch.captured_pixel  = '0;
    box_ch.ready           = 1'b0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part. Start at the reset size of 1920 x 1080 with words at
    // both extremes, equal and unequal, so the first row is partly filled.
    send_pair(32'h0000_0000, 32'h0000_0000);
    send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_pair(32'h0000_0000, 32'hFFFF_FFFF);
    send_pair(32'h8000_0000, 32'h0000_0000);
    send_pair(32'h1234_5678, 32'h1234_5678);

    // Shrink to 3 x 2 in mid-frame: the column counter already stands past
    // the new edge, so the next pixel ends its row. The frame then closes
    // with the box found in the wide first row.
    set_frame(13'd3, 13'd2);
    repeat (4) send_pair(32'hCAFE_F00D, 32'hCAFE_F00D);

    // A frame where nothing differs gives an empty box with the flag clear.
    set_frame(13'd2, 13'd2);
    repeat (4) send_pair(32'h5A5A_A5A5, 32'h5A5A_A5A5);

    // Zero sizes act as a single pixel, so each pair is a frame of its own.
    set_frame(13'd0, 13'd0);
    send_pair(32'h0000_0000, 32'h0000_0001);
    send_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF);

    // A 3 x 3 frame whose changes on two opposite corners and the center
    // make the box grow along both axes.
    set_frame(13'd3, 13'd3);
    send_pair(32'h0000_0001, 32'h0000_0001);
    send_pair(32'h0000_0002, 32'h0000_0002);
    send_pair(32'h0000_0003, 32'h0001_0003);
    send_pair(32'h0000_0004, 32'h0000_0004);
    send_pair(32'h0000_0005, 32'hFFFF_FFFA);
    send_pair(32'h0000_0006, 32'h0000_0006);
    send_pair(32'h0000_0007, 32'h8000_0007);
    send_pair(32'h0000_0008, 32'h0000_0008);
    send_pair(32'h0000_0009, 32'h0000_0009);

    // A width far past the limit with a zero height runs a few pixels along
    // one long row; shrinking to 2 x 1 then closes the frame on the next pixel.
    set_frame(13'd8191, 13'd0);
    repeat (6) send_random_pair($urandom_range(0, 1) == 1);
    set_frame(13'd2, 13'd1);
    send_pair(32'h0000_0000, 32'h0000_0010);

    // A whole 4 x 3 frame ending on a changed pixel in the far corner.
    set_frame(13'd4, 13'd3);
    send_frame(30, 1'b1);

    // Random part. Most settings are small frames sent whole, often with a
    // partial frame left over that the next setting cuts short. A few use
    // oversized frames that only ever see a short run of pixels.
    while (random_pairs < RANDOM_PAIRS || tracker.boxes_owed < RANDOM_BOXES) begin
      sel = $urandom_range(0, 9);
      if (sel == 0) begin
        w = size_t'($urandom_range(9, 8191));
        h = size_t'($urandom_range(0, 8191));
      end else begin
        w = ($urandom_range(0, 15) == 0) ? '0 : size_t'($urandom_range(1, 8));
        h = ($urandom_range(0, 15) == 0) ? '0 : size_t'($urandom_range(1, 6));
      end
      set_frame(w, h);
      frame_pix = tracker.frame_cols() * tracker.frame_rows();
      if (sel == 0) begin
        pairs = $urandom_range(1, 24);
      end else begin
        pairs = $urandom_range(1, 4) * frame_pix;
        if ($urandom_range(0, 1) == 1) pairs += $urandom_range(0, frame_pix - 1);
      end
      case ($urandom_range(0, 4))
        0: pct = 0;
        1: pct = 5;
        2: pct = 20;
        3: pct = 50;
        default: pct = 100;
      endcase
      quiet = ($urandom_range(0, 3) == 0);
      for (int unsigned i = 0; i < pairs; i++) begin
        // Now and then hold back until every owed box has been taken.
        if ($urandom_range(0, 39) == 0) wait_drained();
        send_random_pair($urandom_range(0, 99) < pct);
        random_pairs++;
      end
      quiet = 1'b0;
    end

    @(negedge clk);
    pix_ch.valid <= 1'b0;
    wait_drained();
    repeat (SETTLE_CYCLES * 2) @(posedge clk);

    $display("Sent %0d pixel pairs over %0d frame sizes, from 1 x 1 up to saturated widths.",
             tracker.pairs_seen, size_settings);
    $display("Checked %0d boxes, %0d of them with a change found; %0d mismatches.",
             tracker.boxes_checked, tracker.boxes_with_change, tracker.mismatches);
    if (tracker.pending() != 0)
      $display("%0d boxes never arrived.", tracker.pending());
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("changed_pixel_bounding_box regression: pass");
    end else begin
      $display("changed_pixel_bounding_box regression: fail");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/cpbb_pkg.sv
rtl/cpbb_pix_if.sv
rtl/cpbb_box_if.sv
rtl/cpbb_tracker.sv
rtl/changed_pixel_bounding_box.sv
test/changed_pixel_bounding_box_test.sv
